// File: hw/rtl/mma_pkg.sv
// Shared constants, types and codes for the multichannel moving average block.
package mma_pkg;

  localparam int CHANNELS   = 128;
  localparam int WINDOW_MAX = 64;

  localparam int DATA_W     = 48;
  localparam int FRAC_BITS  = 8;
  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 8;
  localparam int WINCFG_W   = 7;

  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_BITS   = $clog2(WINDOW_MAX);
  localparam int CNT_W      = WIN_BITS + 1;
  localparam int CELL_AW    = CH_BITS + WIN_BITS;
  localparam int CELLS      = 1 << CELL_AW;
  localparam int SUM_W      = DATA_W + WIN_BITS;

  localparam int DIV_RADIX  = 2;
  localparam int DIV_STEPS  = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_CW     = $clog2(DIV_STEPS);
  localparam int QUO_W      = DIV_RADIX * DIV_STEPS;

  localparam longint AVG_LIMIT    = 200000000;
  localparam int     WINDOW_RESET = 60;

  localparam logic [QUO_W-1:0] AVG_MAX = QUO_W'(AVG_LIMIT << FRAC_BITS);

  localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(2);

  typedef enum logic [1:0] {
    K_ECHO,
    K_CLEAR,
    K_READ,
    K_UPDATE
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_DISPATCH,
    ST_SUM,
    ST_DIV,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0]   avg;
    logic [WIN_BITS-1:0] idx;
    logic                wrapped;
  } meta_t;

  typedef struct packed {
    logic init_step;
    logic load;
    logic look;
    logic upd_start;
    logic sum_step;
    logic div_start;
    logic clear_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  init_done;
    kind_t kind;
    logic  sum_done;
    logic  div_done;
    logic  clear_done;
    logic  out_free;
  } stat_t;

endpackage

// File: hw/rtl/multichannel_moving_average.sv
// Top level of the multichannel moving average block.
// A per-channel moving average over ring buffers of 64 cells for 128 channels. Each item
// carries a mode (clear, update, read; the unused code acts as update), a channel and a
// Q39.8 sample, and gives exactly one result. An update writes the sample (negative values
// taken as zero) into the channel's ring, sums the cells in the window one per cycle from
// the ring memory's one read port, divides by the cell count in a two-bit-per-cycle divider and
// saturates the average at 200000000.0. An update sums at most 64 cells and then runs the
// 27-step divider; a clear zeroes the channel's ring one cell a cycle; a read or an
// out-of-range channel does neither. One item is in work at a time; the result sits in an
// output register, so the next item is taken while the last result still waits for its
// transfer. After reset the block sweeps both memories to zero and holds item_stall high
// meanwhile; window_length writes are taken at any time and should be made while the block
// is idle.
module multichannel_moving_average (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              window_length_we,
  input  logic [mma_pkg::WINCFG_W-1:0]      window_length,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [mma_pkg::MODE_W-1:0]        mode,
  input  logic [mma_pkg::CHAN_W-1:0]        channel,
  input  logic signed [mma_pkg::DATA_W-1:0] sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [mma_pkg::DATA_W-1:0] value
);
  import mma_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: accepts an item, then steps the datapath through its work
  mma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath: memories, summing, divide and the result register
  mma_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .mode             (mode),
    .channel          (channel),
    .sample           (sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .value            (value)
  );

endmodule

// File: hw/rtl/mma_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module mma_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mma_pkg::QUO_W-1:0]  dividend,
  input  logic [mma_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [mma_pkg::QUO_W-1:0]  quotient
);
  import mma_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  rem_next;
  logic [QUO_W-1:0]  quo_next;

  always_comb begin
    logic [CNT_W:0] sh;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_RADIX; k++) begin
      sh       = {rem_next, quo_next[QUO_W-1]};
      quo_next = {quo_next[QUO_W-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        rem_next    = CNT_W'(sh - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = sh[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// File: hw/rtl/mma_ctrl.sv
// Sequencing state machine for the moving average block.
module mma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  mma_pkg::stat_t st,
  output mma_pkg::cmd_t  cmd
);
  import mma_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (st.kind)
          K_UPDATE: begin
            cmd.upd_start = 1'b1;
            state_next    = ST_SUM;
          end
          K_CLEAR: state_next = ST_CLEAR;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (st.sum_done) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (st.div_done) state_next = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// File: hw/rtl/mma_datapath.sv
// Datapath: item registers, ring and channel memories, summing, divide, output register.
module mma_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mma_pkg::cmd_t                   cmd,
  output mma_pkg::stat_t                  st,
  input  logic                            window_length_we,
  input  logic [mma_pkg::WINCFG_W-1:0]    window_length,
  input  logic [mma_pkg::MODE_W-1:0]      mode,
  input  logic [mma_pkg::CHAN_W-1:0]      channel,
  input  logic signed [mma_pkg::DATA_W-1:0] sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [mma_pkg::DATA_W-1:0] value
);
  import mma_pkg::*;

  // item registers
  logic [MODE_W-1:0] mode_r;
  logic [CHAN_W-1:0] ch_r;
  logic [DATA_W-1:0] sample_r;
  logic [WINCFG_W-1:0] win;

  // memories
  logic [DATA_W-1:0] cell_mem [CELLS];
  logic [DATA_W-1:0] cell_q;
  meta_t             meta_mem [CHANNELS];
  meta_t             meta_q;

  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [DATA_W-1:0]  cell_wdata;
  logic [CELL_AW-1:0] cell_raddr;
  logic               meta_we;
  logic [CH_BITS-1:0] meta_waddr;
  meta_t              meta_wdata;

  logic [CELL_AW-1:0] init_cnt;
  logic [WIN_BITS-1:0] clr_cnt;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   count;
  logic               pend;
  logic [SUM_W-1:0]   sum;

  logic [CH_BITS-1:0] ch_idx;
  kind_t              kind;
  logic [CNT_W-1:0]   w_eff;
  logic [CNT_W-1:0]   idx_p1;
  logic               issue;
  logic               div_done;
  logic [QUO_W-1:0]   quotient;
  logic [DATA_W-1:0]  avg_clamped;
  meta_t              meta_upd;

  assign ch_idx = ch_r[CH_BITS-1:0];

  always_comb begin
    if ({1'b0, ch_r} >= (CHAN_W+1)'(CHANNELS)) begin
      kind = K_ECHO;
    end else if (mode_r == MODE_CLEAR) begin
      kind = K_CLEAR;
    end else if (mode_r == MODE_READ) begin
      kind = K_READ;
    end else begin
      kind = K_UPDATE;
    end
  end

  always_comb begin
    if (win == '0) begin
      w_eff = CNT_W'(1);
    end else if (win > WINCFG_W'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(win);
    end
  end

  assign idx_p1 = {1'b0, meta_q.idx} + 1'b1;
  assign issue  = rd_idx < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WINCFG_W'(WINDOW_RESET);
    end else if (window_length_we) begin
      win <= window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode;
      ch_r     <= channel;
      sample_r <= sample;
    end
  end

  // memory write port selection
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = {ch_idx, meta_q.idx};
    cell_wdata = '0;
    if (cmd.init_step) begin
      cell_we    = 1'b1;
      cell_waddr = init_cnt;
    end else if (cmd.clear_step) begin
      cell_we    = 1'b1;
      cell_waddr = {ch_idx, clr_cnt};
    end else if (cmd.upd_start) begin
      cell_we    = 1'b1;
      cell_wdata = sample_r[DATA_W-1] ? '0 : sample_r;
    end
  end

  assign cell_raddr = {ch_idx, rd_idx[WIN_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_q <= cell_mem[cell_raddr];
  end

  assign avg_clamped = (quotient > AVG_MAX) ? DATA_W'(AVG_MAX) : quotient[DATA_W-1:0];

  always_comb begin
    meta_upd.avg = avg_clamped;
    if (idx_p1 < w_eff) begin
      meta_upd.idx     = idx_p1[WIN_BITS-1:0];
      meta_upd.wrapped = meta_q.wrapped;
    end else begin
      meta_upd.idx     = '0;
      meta_upd.wrapped = 1'b1;
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = ch_idx;
    meta_wdata = '0;
    if (cmd.init_step) begin
      meta_we    = {1'b0, init_cnt} < (CELL_AW+1)'(CHANNELS);
      meta_waddr = init_cnt[CH_BITS-1:0];
    end else if (cmd.finish && kind == K_CLEAR) begin
      meta_we = 1'b1;
    end else if (cmd.finish && kind == K_UPDATE) begin
      meta_we    = 1'b1;
      meta_wdata = meta_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (cmd.look) meta_q <= meta_mem[ch_idx];
  end

  // sweeps and window sum
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
    end else if (cmd.init_step) begin
      init_cnt <= init_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      sum    <= '0;
      count  <= meta_q.wrapped ? w_eff : idx_p1;
    end else if (cmd.sum_step) begin
      if (issue) rd_idx <= rd_idx + 1'b1;
      pend <= issue;
      if (pend) sum <= sum + SUM_W'(cell_q);
    end
  end

  mma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (QUO_W'(sum)),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (kind)
        K_READ:   value <= meta_q.avg;
        K_UPDATE: value <= avg_clamped;
        default:  value <= sample_r;
      endcase
    end
  end

  always_comb begin
    st.init_done  = init_cnt == CELL_AW'(CELLS - 1);
    st.kind       = kind;
    st.sum_done   = !pend && (rd_idx == count);
    st.div_done   = div_done;
    st.clear_done = clr_cnt == WIN_BITS'(WINDOW_MAX - 1);
    st.out_free   = !result_valid || !result_stall;
  end

endmodule

// File: hw/rtl/mma_checker.sv
// Port-level checks for the moving average block, bound to the top level.
module mma_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic signed [mma_pkg::DATA_W-1:0] value
);

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while busy");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // memory clearing sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("item taken during clearing sweep");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);
